>>> hdl/assert_macros.svh
// Assertion macros used by the checker module of the frame transmitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define FTX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define FTX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ftx_pkg.sv
// Package with types and constants of the loop frame pulse transmitter.
`default_nettype none

package ftx_pkg;

  localparam int FrameBits  = 11;
  localparam int TicksW     = 8;
  localparam int PosW       = 4;
  localparam int PhaseW     = 3;
  localparam int CfgIdxW    = 2;
  localparam int QueueDepth = 2;

  typedef logic [FrameBits-1:0] frame_t;
  typedef logic [TicksW-1:0]    ticks_t;
  typedef logic [PosW-1:0]      pos_t;
  typedef logic [PhaseW-1:0]    phase_t;
  typedef logic [CfgIdxW-1:0]   cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_PULSE_TICKS = 2'd0;
  localparam cfg_idx_t CFG_GAP_TICKS   = 2'd1;

  localparam ticks_t PulseTicksRst = 8'd18;
  localparam ticks_t GapTicksRst   = 8'd36;

  // The sync bit sends two pulse pairs, every other bit one, then a gap.
  localparam phase_t SyncGapPhase = 3'd4;
  localparam phase_t BitGapPhase  = 3'd2;
  localparam pos_t   LastBitPos   = 4'd10;

  // Head of the frame queue as seen by the back end.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_head_t;

  // A register value of zero is held for one tick.
  function automatic ticks_t held_len(input ticks_t v);
    held_len = (v == '0) ? ticks_t'(1) : v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ftx_if.sv
// Channel interfaces: frame input and waveform segment output.
`default_nettype none

interface ftx_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] control_bits;
  logic [7:0] data_byte;

  modport source (output valid, output control_bits, output data_byte, input ready);
  modport sink   (input valid, input control_bits, input data_byte, output ready);
endinterface

interface ftx_out_if;
  logic       valid;
  logic       ready;
  logic       line_a;
  logic       line_b;
  logic [7:0] hold_ticks;
  logic [3:0] bit_position;
  logic       last_segment;

  modport source (output valid, output line_a, output line_b, output hold_ticks,
                  output bit_position, output last_segment, input ready);
  modport sink   (input valid, input line_a, input line_b, input hold_ticks,
                  input bit_position, input last_segment, output ready);
endinterface

`default_nettype wire

>>> hdl/ftx_queue.sv
// Front end: accepts frames, packs them into 11-bit words and queues them.
`default_nettype none

module ftx_queue #(
  parameter int DEPTH = ftx_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ftx_in_if.sink           in_chan,
  output ftx_pkg::q_head_t head,
  input  wire logic        pop
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ftx_pkg::frame_t entry_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            push;

  assign in_chan.ready = (count_r != CntW'(DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign head.valid    = (count_r != '0);
  assign head.frame    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= {in_chan.control_bits, in_chan.data_byte};
    end
  end

endmodule

`default_nettype wire

>>> hdl/ftx_back.sv
// Back end: holds the timing registers and steps through the segments of a frame.
`default_nettype none

module ftx_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire ftx_pkg::cfg_idx_t cfg_index,
  input  wire ftx_pkg::ticks_t   cfg_wdata,
  input  wire ftx_pkg::q_head_t  head,
  output logic                   pop,
  ftx_out_if.source              out_chan
);

  ftx_pkg::ticks_t pulse_ticks_r;
  ftx_pkg::ticks_t gap_ticks_r;
  ftx_pkg::pos_t   bit_idx_r, bit_idx_nxt;
  ftx_pkg::phase_t phase_r, phase_nxt;
  ftx_pkg::phase_t gap_phase;
  ftx_pkg::pos_t   sel;
  logic            bit_val;
  logic            is_gap;
  logic            is_last;
  logic            emit;

  logic            out_valid_r, out_valid_nxt;
  logic            line_a_r, line_b_r, last_r;
  ftx_pkg::ticks_t hold_r;
  ftx_pkg::pos_t   pos_r;

  // Frame bit 0 (the sync bit) sits in the top position of the packed word.
  assign sel       = ftx_pkg::pos_t'(ftx_pkg::FrameBits - 1) - bit_idx_r;
  assign bit_val   = head.frame[sel];
  assign gap_phase = (bit_idx_r == '0) ? ftx_pkg::SyncGapPhase : ftx_pkg::BitGapPhase;
  assign is_gap    = (phase_r == gap_phase);
  assign is_last   = (bit_idx_r == ftx_pkg::LastBitPos);
  assign emit      = head.valid && (!out_valid_r || out_chan.ready);
  assign pop       = emit && is_gap && is_last;

  always_comb begin
    bit_idx_nxt = bit_idx_r;
    phase_nxt   = phase_r;
    if (emit) begin
      if (is_gap) begin
        phase_nxt   = '0;
        bit_idx_nxt = is_last ? '0 : bit_idx_r + 1'b1;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r <= ftx_pkg::PulseTicksRst;
      gap_ticks_r   <= ftx_pkg::GapTicksRst;
      bit_idx_r     <= '0;
      phase_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ftx_pkg::CFG_PULSE_TICKS: pulse_ticks_r <= cfg_wdata;
          ftx_pkg::CFG_GAP_TICKS:   gap_ticks_r   <= cfg_wdata;
          default: ;
        endcase
      end
      bit_idx_r   <= bit_idx_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Even pulse phases drive the bit's first line, odd phases the other one.
  always_ff @(posedge clk) begin
    if (emit) begin
      pos_r  <= bit_idx_r;
      last_r <= is_gap && is_last;
      if (is_gap) begin
        line_a_r <= 1'b0;
        line_b_r <= 1'b0;
        hold_r   <= ftx_pkg::held_len(gap_ticks_r);
      end else begin
        line_a_r <= bit_val ^ phase_r[0];
        line_b_r <= ~(bit_val ^ phase_r[0]);
        hold_r   <= ftx_pkg::held_len(pulse_ticks_r);
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.line_a       = line_a_r;
  assign out_chan.line_b       = line_b_r;
  assign out_chan.hold_ticks   = hold_r;
  assign out_chan.bit_position = pos_r;
  assign out_chan.last_segment = last_r;

endmodule

`default_nettype wire

>>> hdl/loop_frame_pulse_transmitter_top.sv
// Top level of the loop frame pulse transmitter.
//
// The input channel in_chan takes one 11-bit loop frame per transaction:
// control_bits (bit 2 is the sync bit) and data_byte (sent MSB first).
// The output channel out_chan delivers 35 waveform segments per frame, each
// giving the levels of lines A and B, how many ticks they are held, the
// frame bit position and a flag on the final gap segment.
// The first segment of a frame is registered on out_chan after the frame is
// written into the queue. The back-end sequencer emits one segment per cycle
// while a frame is queued and the receiver is ready; it sets the throughput.
// A two-entry frame queue sits between input and sequencer, so new frames
// are taken while the previous one is still being sent.
// The cfg port writes pulse_ticks (index 0) and gap_ticks (index 1); a value
// of zero is held as one tick. Write them only while the block is idle.
// Reset (rst_n low, synchronous) empties the queue, drops any pending
// segment and loads pulse_ticks = 18 and gap_ticks = 36.
// When the receiver stalls, the current segment stays on out_chan unchanged
// and the sequencer waits; the queue fills and then in_chan.ready drops.
`default_nettype none

module loop_frame_pulse_transmitter_top #(
  parameter int QUEUE_DEPTH = ftx_pkg::QueueDepth
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  ftx_in_if.sink                 in_chan,
  ftx_out_if.source              out_chan,
  input  wire logic              cfg_we,
  input  wire ftx_pkg::cfg_idx_t cfg_index,
  input  wire ftx_pkg::ticks_t   cfg_wdata
);

  ftx_pkg::q_head_t head;
  logic             pop;

  ftx_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_chan(in_chan),
    .head   (head),
    .pop    (pop)
  );

  ftx_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

>>> hdl/ftx_checker.sv
// Port-level checker for the frame transmitter and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module ftx_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       line_a,
  input wire logic       line_b,
  input wire logic [7:0] hold_ticks,
  input wire logic [3:0] bit_position,
  input wire logic       last_segment
);

  `FTX_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(hold_ticks) && $stable(bit_position) && $stable(line_a) && $stable(line_b), "stalled segment changed")
  `FTX_ASSERT_IMP(a_one_line, out_valid, !(line_a && line_b), "both lines driven high")
  `FTX_ASSERT_IMP(a_hold_nonzero, out_valid, hold_ticks != 8'd0, "zero hold time")
  `FTX_ASSERT_IMP(a_last_gap, out_valid && last_segment, !line_a && !line_b && bit_position == 4'd10, "last segment is not the final gap")
  `FTX_ASSERT_NXT(a_next_frame, out_valid && out_ready && last_segment, !out_valid || bit_position == 4'd0, "frame does not restart at sync bit")

endmodule

bind loop_frame_pulse_transmitter_top ftx_checker u_ftx_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .line_a      (out_chan.line_a),
  .line_b      (out_chan.line_b),
  .hold_ticks  (out_chan.hold_ticks),
  .bit_position(out_chan.bit_position),
  .last_segment(out_chan.last_segment)
);

`default_nettype wire

>>> tb/sv/loop_frame_pulse_transmitter_top_tb.sv
// Self-checking testbench that compares every waveform segment of the frame transmitter.
module loop_frame_pulse_transmitter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ftx_pkg::*;

  // Indexes that the block does not decode; writes to them must change nothing.
  localparam cfg_idx_t CfgSpareIdxA = 2'd2;
  localparam cfg_idx_t CfgSpareIdxB = 2'd3;

  localparam int PhaseFrames  = 70;
  localparam int LongHoldLen  = 400;
  localparam int HoldAtFrame  = 120;
  localparam int SettleCycles = 40;

  typedef struct packed {
    logic   line_a;
    logic   line_b;
    ticks_t hold;
    pos_t   pos;
    logic   last;
  } wave_seg_t;

  // Expected waveform segments of accepted frames not yet checked, oldest first.
  class frame_wave_book;
    wave_seg_t due[$];
    ticks_t    pulse_len;
    ticks_t    gap_len;
    int        frames;
    int        segs;
    int        errors;

    function new();
      pulse_len = PulseTicksRst;
      gap_len   = GapTicksRst;
      frames    = 0;
      segs      = 0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, ticks_t v);
      case (idx)
        CFG_PULSE_TICKS: pulse_len = v;
        CFG_GAP_TICKS:   gap_len = v;
        default: ;
      endcase
    endfunction

    function void add_seg(logic a, logic b, ticks_t h, pos_t p, logic l);
      due.push_back({a, b, h, p, l});
    endfunction

    function void note_frame(logic [2:0] ctrl, logic [7:0] data);
      frame_t fr;
      ticks_t ph;
      ticks_t gp;
      logic   b;
      int     pairs;
      fr = {ctrl, data};
      // A zero register still holds the lines for one tick.
      ph = (pulse_len == '0) ? ticks_t'(1) : pulse_len;
      gp = (gap_len == '0) ? ticks_t'(1) : gap_len;
      for (int i = 0; i < FrameBits; i++) begin
        b = fr[FrameBits-1-i];
        pairs = (i == 0) ? 2 : 1;
        repeat (pairs) begin
          add_seg(b, !b, ph, pos_t'(i), 1'b0);
          add_seg(!b, b, ph, pos_t'(i), 1'b0);
        end
        add_seg(1'b0, 1'b0, gp, pos_t'(i), i == FrameBits - 1);
      end
      frames++;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_seg(wave_seg_t got);
      wave_seg_t want;
      if (due.size() == 0) begin
        report($sformatf("segment a=%0b b=%0b hold=%0d pos=%0d last=%0b with no frame pending",
                         got.line_a, got.line_b, got.hold, got.pos, got.last));
        return;
      end
      want = due.pop_front();
      segs++;
      if (got.line_a !== want.line_a)
        report($sformatf("segment %0d line_a %0b, want %0b", segs, got.line_a, want.line_a));
      if (got.line_b !== want.line_b)
        report($sformatf("segment %0d line_b %0b, want %0b", segs, got.line_b, want.line_b));
      if (got.hold !== want.hold)
        report($sformatf("segment %0d hold_ticks %0d, want %0d", segs, got.hold, want.hold));
      if (got.pos !== want.pos)
        report($sformatf("segment %0d bit_position %0d, want %0d", segs, got.pos, want.pos));
      if (got.last !== want.last)
        report($sformatf("segment %0d last_segment %0b, want %0b", segs, got.last, want.last));
    endtask

    function int pending();
      return due.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  ticks_t   cfg_wdata;
  logic     sink_hold;
  bit       tx_calm;
  int       settings_run;
  int       hold_cycles;

  frame_wave_book book = new();

  ftx_in_if  in_chan();
  ftx_out_if out_chan();

  loop_frame_pulse_transmitter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      book.note_frame(in_chan.control_bits, in_chan.data_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      book.check_seg({out_chan.line_a, out_chan.line_b, out_chan.hold_ticks,
                      out_chan.bit_position, out_chan.last_segment});
  end

  // Receiver: after each transaction it picks a random ready gap, zero in calm stretches.
  initial begin
    int unsigned gap;
    int unsigned seen;
    bit          calm;
    gap = 0;
    seen = 0;
    calm = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) begin
        seen++;
        if (seen % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        gap = calm ? 0 : $urandom_range(0, 8);
      end
      if (sink_hold || gap != 0) begin
        out_chan.ready <= 1'b0;
        if (!sink_hold) gap--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // One long receiver stall mid-run, so the frame queue fills and input backs up.
  initial begin
    int held;
    sink_hold <= 1'b0;
    hold_cycles = 0;
    do @(posedge clk); while (book.frames < HoldAtFrame);
    sink_hold <= 1'b1;
    for (held = 0; held < LongHoldLen; held++) @(posedge clk);
    sink_hold <= 1'b0;
    hold_cycles = held;
  end

  initial begin
    #10ms;
    $display("loop_frame_pulse_transmitter_top_tb: FAIL");
    $finish;
  end

  task automatic send_frame(input logic [2:0] ctrl, input logic [7:0] data);
    int unsigned idle;
    idle = tx_calm ? 0 : $urandom_range(0, 8);
    if (idle != 0) begin
      in_chan.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.control_bits <= ctrl;
    in_chan.data_byte    <= data;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Registers may only change once the last segment of every frame is out.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  task automatic program_regs(input ticks_t pulse, input ticks_t gap, input bit spare);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PULSE_TICKS;
    cfg_wdata <= pulse;
    @(posedge clk);
    book.set_reg(CFG_PULSE_TICKS, pulse);
    cfg_index <= CFG_GAP_TICKS;
    cfg_wdata <= gap;
    @(posedge clk);
    book.set_reg(CFG_GAP_TICKS, gap);
    if (spare) begin
      cfg_index <= CfgSpareIdxA;
      cfg_wdata <= ~pulse;
      @(posedge clk);
      book.set_reg(CfgSpareIdxA, ~pulse);
      cfg_index <= CfgSpareIdxB;
      cfg_wdata <= ~gap;
      @(posedge clk);
      book.set_reg(CfgSpareIdxB, ~gap);
    end
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin
    logic [7:0] corner_data [8];
    ticks_t     pulse_set [6];
    ticks_t     gap_set [6];
    corner_data = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h80, 8'h01, 8'h7F, 8'hFE};
    pulse_set   = '{8'd1, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0};
    gap_set     = '{8'd1, 8'd255, 8'd0, 8'd1, 8'd0, 8'd0};
    settings_run = 1;
    tx_calm = 1'b0;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.control_bits <= '0;
    in_chan.data_byte    <= '0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_PULSE_TICKS;
    cfg_wdata            <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every control pattern against corner data bytes, at the reset lengths.
    for (int i = 0; i < 8; i++) send_frame(3'(i), corner_data[i]);
    wait_drained();

    for (int k = 0; k < 6; k++) begin
      if (k >= 4) begin
        pulse_set[k] = ticks_t'($urandom_range(0, 255));
        gap_set[k]   = ticks_t'($urandom_range(0, 255));
      end
      program_regs(pulse_set[k], gap_set[k], k == 2 || k == 5);
      for (int n = 0; n < PhaseFrames; n++) begin
        if (n % 32 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        send_frame(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
      wait_drained();
    end

    // Give a stray extra segment time to show up.
    repeat (SettleCycles) @(posedge clk);
    if (book.pending() != 0)
      book.report($sformatf("%0d expected segments never arrived", book.pending()));

    $display("Sent %0d frames over %0d register settings (zero, one and 255 tick lengths),",
             book.frames, settings_run);
    $display("checked %0d segments; receiver held off once for %0d cycles.",
             book.segs, hold_cycles);
    if (book.errors == 0) begin
      $display("loop_frame_pulse_transmitter_top_tb: PASS");
    end else begin
      $display("loop_frame_pulse_transmitter_top_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/ftx_pkg.sv
hdl/ftx_if.sv
hdl/ftx_queue.sv
hdl/ftx_back.sv
hdl/loop_frame_pulse_transmitter_top.sv
hdl/ftx_checker.sv
tb/sv/loop_frame_pulse_transmitter_top_tb.sv
